// ===== hdl/rasz_pkg.sv =====
// Shared types, codes and the 5x7 font table for the clipped rectangle and glyph rasterizer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package rasz_pkg;

  // Command codes on the input tuser
  localparam logic [1:0] OP_FILL    = 2'd0;
  localparam logic [1:0] OP_OUTLINE = 2'd1;
  localparam logic [1:0] OP_GLYPH   = 2'd2;

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THICKNESS = 2'd2;

  localparam int MAX_THICKNESS = 8;
  localparam int RING_W        = $clog2(MAX_THICKNESS + 1);
  localparam int GLYPH_W       = 5;
  localparam int GLYPH_H       = 7;
  localparam int GLYPH_BITS    = GLYPH_W * GLYPH_H;
  localparam int COL_W         = $clog2(GLYPH_W);
  localparam int ROW_W         = $clog2(GLYPH_H);

  // Command queue depth, a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    K_FILL,
    K_OUTLINE,
    K_GLYPH
  } kind_t;

  // One classified command, as queued between front and back
  typedef struct packed {
    kind_t                   kind;
    logic signed [15:0]      x0;
    logic signed [15:0]      y0;
    logic signed [15:0]      x1;
    logic signed [15:0]      y1;
    logic [GLYPH_BITS-1:0]   bitmap;
    logic [15:0]             color;
  } job_t;

  // One clipped rectangle write
  typedef struct packed {
    logic [15:0] color;
    logic [11:0] ye;
    logic [11:0] xe;
    logic [11:0] ys;
    logic [11:0] xs;
  } wr_t;

  // Clipping limits handed to the back end
  typedef struct packed {
    logic [11:0]       wmax;
    logic [11:0]       hmax;
    logic [RING_W-1:0] rings;
  } geom_t;

  // Font lookup: row 0 in the top bits, leftmost column as MSB of each row.
  // Lower case folds to upper case; anything not in the table draws '?'.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
    logic [7:0] c;
    logic [GLYPH_BITS-1:0] g;
    c = code;
    if (code >= 8'h61 && code <= 8'h7a) begin
      c = code - 8'd32;
    end
    case (c)
      8'h20: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      8'h25: g = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
      8'h2d: g = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
      8'h2e: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04};
      8'h3a: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      8'h30: g = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
      8'h31: g = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h32: g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
      8'h33: g = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
      8'h34: g = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
      8'h35: g = {5'h1f, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h11, 5'h0e};
      8'h36: g = {5'h06, 5'h08, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
      8'h37: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: g = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
      8'h39: g = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h02, 5'h0c};
      8'h41: g = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h42: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
      8'h43: g = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
      8'h44: g = {5'h1c, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1c};
      8'h45: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
      8'h46: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
      8'h47: g = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0e};
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h49: g = {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h4a: g = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0e};
      8'h4b: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      8'h4c: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
      8'h4d: g = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4e: g = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
      8'h4f: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h50: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
      8'h51: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
      8'h52: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
      8'h53: g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
      8'h54: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
      8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
      8'h58: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
      8'h59: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5a: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
      default: g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rasz_front.sv =====
// Command front end: accepts draw command beats, orders corners, fetches glyph bitmaps.
// Depends on rasz_pkg; feeds rasz_queue.
`default_nettype none

module rasz_front (
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  // x_first[15:0], y_first[31:16], x_second[47:32], y_second[63:48],
  // char_code[71:64], draw_color[87:72]
  input  wire logic [87:0]     s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]      s_tuser,
  input  wire logic            full,
  output logic                 push,
  output rasz_pkg::job_t       push_data
);

  logic signed [15:0] xa, ya, xb, yb;
  logic [7:0]         code;
  logic [15:0]        color;

  assign xa    = s_tdata[15:0];
  assign ya    = s_tdata[31:16];
  assign xb    = s_tdata[47:32];
  assign yb    = s_tdata[63:48];
  assign code  = s_tdata[71:64];
  assign color = s_tdata[87:72];

  // Take a beat whenever the queue has room; drop opcodes past the glyph command
  assign s_tready = !full;
  assign push     = s_tvalid && !full && (s_tuser <= rasz_pkg::OP_GLYPH);

  // Classify and order corners
  always_comb begin
    push_data        = '0;
    push_data.color  = color;
    push_data.bitmap = rasz_pkg::glyph_bits(code);
    case (s_tuser)
      rasz_pkg::OP_FILL:    push_data.kind = rasz_pkg::K_FILL;
      rasz_pkg::OP_OUTLINE: push_data.kind = rasz_pkg::K_OUTLINE;
      default:              push_data.kind = rasz_pkg::K_GLYPH;
    endcase
    if (s_tuser == rasz_pkg::OP_GLYPH) begin
      // Glyph keeps its origin in both corners; x1 reloads the column at row end
      push_data.x0 = xa;
      push_data.x1 = xa;
      push_data.y0 = ya;
      push_data.y1 = ya;
    end else begin
      push_data.x0 = (xa < xb) ? xa : xb;
      push_data.x1 = (xa < xb) ? xb : xa;
      push_data.y0 = (ya < yb) ? ya : yb;
      push_data.y1 = (ya < yb) ? yb : ya;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rasz_queue.sv =====
// Short command queue between the front end and the write generator.
// Depends on rasz_pkg for the job type and depth.
`default_nettype none

module rasz_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rasz_pkg::job_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 pop_valid,
  output rasz_pkg::job_t       pop_data
);

  rasz_pkg::job_t                mem [rasz_pkg::QUEUE_DEPTH];
  logic [rasz_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rasz_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rasz_pkg::QPTR_W:0]     count;

  assign full      = (count == (rasz_pkg::QPTR_W + 1)'(rasz_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop && pop_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rasz_back.sv =====
// Write generator: emits clipped writes, walking one queued command a step per cycle
// unless stalled. Uses rasz_pkg; pulls from rasz_queue, drives the output register.
`default_nettype none

module rasz_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rasz_pkg::geom_t geom,
  input  wire logic            job_valid,
  input  wire rasz_pkg::job_t  job,
  output logic                 job_pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output rasz_pkg::wr_t        m_wr,
  output logic                 m_tlast
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  state_t                          state;
  rasz_pkg::kind_t                 kind;
  logic [15:0]                     color;
  logic signed [17:0]              lft, rgt, top, bot;
  logic [rasz_pkg::GLYPH_BITS-1:0] bitmap;
  logic [rasz_pkg::RING_W-1:0]     ring;
  logic [1:0]                      side;
  logic [rasz_pkg::ROW_W-1:0]      row;
  logic [rasz_pkg::COL_W-1:0]      col;

  rasz_pkg::wr_t                   pend;
  logic                            pend_valid;

  rasz_pkg::wr_t                   cand;
  logic                            cand_valid;
  logic                            step_done;
  logic                            out_free;
  logic                            adv;
  logic                            push_mid;
  logic                            push_last;
  logic [11:0]                     cl, cr, ct, cb;
  logic                            l_in, r_in, t_in, b_in;

  function automatic logic [11:0] clip(input logic signed [17:0] v, input logic [11:0] mx);
    logic [11:0] r;
    if (v[17]) begin
      r = 12'd0;
    end else if (v[16:0] > {5'd0, mx}) begin
      r = mx;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  function automatic logic on_screen(input logic signed [17:0] v, input logic [11:0] mx);
    return !v[17] && (v[16:0] <= {5'd0, mx});
  endfunction

  // Clip the current edges
  always_comb begin
    cl   = clip(lft, geom.wmax);
    cr   = clip(rgt, geom.wmax);
    ct   = clip(top, geom.hmax);
    cb   = clip(bot, geom.hmax);
    l_in = on_screen(lft, geom.wmax);
    r_in = on_screen(rgt, geom.wmax);
    t_in = on_screen(top, geom.hmax);
    b_in = on_screen(bot, geom.hmax);
  end

  // Candidate write for this step and end of command
  always_comb begin
    cand       = '0;
    cand.color = color;
    cand_valid = 1'b0;
    step_done  = 1'b0;
    case (kind)
      rasz_pkg::K_FILL: begin
        cand.xs    = cl;
        cand.ys    = ct;
        cand.xe    = cr;
        cand.ye    = cb;
        cand_valid = 1'b1;
        step_done  = 1'b1;
      end
      rasz_pkg::K_OUTLINE: begin
        // Stop at ring count or once the ring turns inside out
        if (side == 2'd0 && (ring == geom.rings || lft > rgt || top > bot)) begin
          step_done = 1'b1;
        end else begin
          case (side)
            2'd0: begin
              cand.xs = cl; cand.xe = cr; cand.ys = top[11:0]; cand.ye = top[11:0];
              cand_valid = t_in;
            end
            2'd1: begin
              cand.xs = cl; cand.xe = cr; cand.ys = bot[11:0]; cand.ye = bot[11:0];
              cand_valid = b_in;
            end
            2'd2: begin
              cand.xs = lft[11:0]; cand.xe = lft[11:0]; cand.ys = ct; cand.ye = cb;
              cand_valid = l_in;
            end
            default: begin
              cand.xs = rgt[11:0]; cand.xe = rgt[11:0]; cand.ys = ct; cand.ye = cb;
              cand_valid = r_in;
            end
          endcase
        end
      end
      default: begin
        // Glyph pixel: lft is the column, top the row
        cand.xs    = lft[11:0];
        cand.xe    = lft[11:0];
        cand.ys    = top[11:0];
        cand.ye    = top[11:0];
        cand_valid = bitmap[rasz_pkg::GLYPH_BITS-1] && l_in && t_in;
        step_done  = (row == rasz_pkg::ROW_W'(rasz_pkg::GLYPH_H - 1)) &&
                     (col == rasz_pkg::COL_W'(rasz_pkg::GLYPH_W - 1));
      end
    endcase
  end

  // Handshake between generator, pending write and output register
  assign out_free  = !m_tvalid || m_tready;
  assign adv       = (state == S_RUN) && (!(cand_valid && pend_valid) || out_free);
  assign push_mid  = adv && cand_valid && pend_valid;
  assign push_last = (state == S_FLUSH) && pend_valid && out_free;
  assign job_pop   = (state == S_IDLE) && job_valid;

  // Sequencer, pending write and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // Output register: load a finished write, drop it once taken
      if (push_mid || push_last) begin
        m_tvalid <= 1'b1;
        m_wr     <= pend;
        m_tlast  <= push_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (job_valid) begin
            kind   <= job.kind;
            color  <= job.color;
            bitmap <= job.bitmap;
            lft    <= 18'(job.x0);
            rgt    <= 18'(job.x1);
            top    <= 18'(job.y0);
            bot    <= 18'(job.y1);
            ring   <= '0;
            side   <= '0;
            row    <= '0;
            col    <= '0;
            state  <= S_RUN;
          end
        end
        S_RUN: begin
          if (adv) begin
            if (cand_valid) begin
              pend       <= cand;
              pend_valid <= 1'b1;
            end
            // Advance the walk
            if (kind == rasz_pkg::K_OUTLINE) begin
              side <= side + 2'd1;
              if (side == 2'd3) begin
                ring <= ring + 1'b1;
                lft  <= lft + 18'sd1;
                rgt  <= rgt - 18'sd1;
                top  <= top + 18'sd1;
                bot  <= bot - 18'sd1;
              end
            end else if (kind == rasz_pkg::K_GLYPH) begin
              bitmap <= bitmap << 1;
              if (col == rasz_pkg::COL_W'(rasz_pkg::GLYPH_W - 1)) begin
                col <= '0;
                row <= row + 1'b1;
                lft <= rgt;
                top <= top + 18'sd1;
              end else begin
                col <= col + 1'b1;
                lft <= lft + 18'sd1;
              end
            end
            if (step_done) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          // Release the held write as the last of the run
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/clipped_rect_and_glyph_rasterizer.sv =====
// Top level of the clipped rectangle, outline and 5x7 glyph rasterizer with APB registers.
// Depends on rasz_pkg, rasz_front, rasz_queue and rasz_back.
//
//   channel  | dir | sideband        | data
//   ---------+-----+-----------------+-----------------------------------------------
//   s_       | in  | tuser = opcode  | x/y first, x/y second, char_code, draw_color
//   m_       | out | tlast = last    | x/y start, x/y end, write_color
//   APB      | in  | -               | screen_width, screen_height, outline_thickness
//
// Each command is loaded, walked one step at a time and then flushed:
// a fill is a single clipped write, an outline takes one step per side of each ring
// (ending early once a ring inverts), a glyph one step per font pixel.
// The walk runs in rasz_back; a two-entry queue lets new beats in while it runs.
// Synchronous active-high reset empties the queue and output and restores 320x240, 2 rings.
// A stalled m_tready holds the output beat and pauses the walk once a second write is ready.
`default_nettype none

module clipped_rect_and_glyph_rasterizer (
  input  wire logic        clk,
  input  wire logic        rst,
  // command stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // x_first[15:0], y_first[31:16], x_second[47:32], y_second[63:48],
  // char_code[71:64], draw_color[87:72]
  input  wire logic [87:0] s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_tuser,
  // write stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // rect_x_start[11:0], rect_y_start[23:12], rect_x_end[35:24], rect_y_end[47:36],
  // write_color[63:48]
  output logic [63:0]      m_tdata,
  output logic             m_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [12:0]          screen_width;
  logic [12:0]          screen_height;
  logic [3:0]           outline_thickness;
  rasz_pkg::geom_t      geom;

  logic                 push;
  rasz_pkg::job_t       push_data;
  logic                 full;
  logic                 pop;
  logic                 pop_valid;
  rasz_pkg::job_t       pop_data;
  rasz_pkg::wr_t        m_wr;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width      <= 13'd320;
      screen_height     <= 13'd240;
      outline_thickness <= 4'd2;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        rasz_pkg::REG_WIDTH:     screen_width      <= pwdata[12:0];
        rasz_pkg::REG_HEIGHT:    screen_height     <= pwdata[12:0];
        rasz_pkg::REG_THICKNESS: outline_thickness <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      rasz_pkg::REG_WIDTH:     prdata = {19'd0, screen_width};
      rasz_pkg::REG_HEIGHT:    prdata = {19'd0, screen_height};
      rasz_pkg::REG_THICKNESS: prdata = {28'd0, outline_thickness};
      default:                 prdata = 32'd0;
    endcase
  end

  // Effective clip limits: size 0 acts as 1, above 4096 acts as 4096
  always_comb begin
    if (screen_width == 13'd0) begin
      geom.wmax = 12'd0;
    end else if (screen_width >= 13'd4096) begin
      geom.wmax = 12'd4095;
    end else begin
      geom.wmax = screen_width[11:0] - 12'd1;
    end
    if (screen_height == 13'd0) begin
      geom.hmax = 12'd0;
    end else if (screen_height >= 13'd4096) begin
      geom.hmax = 12'd4095;
    end else begin
      geom.hmax = screen_height[11:0] - 12'd1;
    end
    if (outline_thickness > 4'(rasz_pkg::MAX_THICKNESS)) begin
      geom.rings = rasz_pkg::RING_W'(rasz_pkg::MAX_THICKNESS);
    end else begin
      geom.rings = rasz_pkg::RING_W'(outline_thickness);
    end
  end

  rasz_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  rasz_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  rasz_back u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .job_valid (pop_valid),
    .job       (pop_data),
    .job_pop   (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_wr      (m_wr),
    .m_tlast   (m_tlast)
  );

  assign m_tdata = m_wr;

endmodule

`default_nettype wire
